FILE: design/invalidation_history_ring_top_assert.svh
// Assertion macros shared by the invalidation history ring RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INVALIDATION_HISTORY_RING_TOP_ASSERT_SVH
`define INVALIDATION_HISTORY_RING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define IHR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define IHR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ihr_pkg.sv
// Package for the invalidation history ring: sizes, command codes, shared structs.
// Depends on nothing; imported by every module of the block except ihr_ram.
package ihr_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int GEN_W         = 64;
    localparam int KEY_W         = 64;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    // Holds a distance of 0 .. HISTORY_DEPTH and slot sums below twice the depth.
    localparam int SPAN_W        = SLOT_W + 1;
    localparam int ENTRY_W       = GEN_W + KEY_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SPAN_W-1:0] DEPTH_SPAN = SPAN_W'(HISTORY_DEPTH);

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    // Access request from the sequencer to the ring storage.
    typedef struct packed {
        logic              wr_en;
        logic              clear_all;
        logic [SLOT_W-1:0] wr_idx;
        logic [GEN_W-1:0]  wr_stamp;
        logic [KEY_W-1:0]  wr_key;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
    } ring_req_t;

    // Entry returned in the cycle after a read.
    typedef struct packed {
        logic [GEN_W-1:0] stamp;
        logic [KEY_W-1:0] key;
    } ring_rsp_t;

    typedef struct packed {
        logic             flag;
        logic [GEN_W-1:0] gen;
    } result_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

endpackage

FILE: design/ihr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ihr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ihr_ring.sv
// Ring storage: stamp and key per slot in one RAM, plus per-slot stamp valid bits.
// Depends on ihr_pkg and ihr_ram.
module ihr_ring
    import ihr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ring_req_t req,
    output ring_rsp_t rsp
);

    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [HISTORY_DEPTH-1:0] valid_next;
    logic                     rd_valid_reg;
    logic [ENTRY_W-1:0]       rdata;

    ihr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (req.wr_idx),
        .wdata ({req.wr_stamp, req.wr_key}),
        .re    (req.rd_en),
        .raddr (req.rd_idx),
        .rdata (rdata)
    );

    // A slot whose valid bit is clear reads with a zero stamp; keys are kept.
    always_comb begin
        valid_next = valid_reg;
        if (req.clear_all) begin
            valid_next = '0;
        end
        if (req.wr_en) begin
            valid_next[req.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        if (req.rd_en) begin
            rd_valid_reg <= valid_reg[req.rd_idx];
        end
    end

    assign rsp.stamp = rd_valid_reg ? rdata[ENTRY_W-1:KEY_W] : '0;
    assign rsp.key   = rdata[KEY_W-1:0];

endmodule

FILE: design/ihr_seq.sv
// Sequencer: generation counter, record writes and the slot-by-slot query walk.
// Depends on ihr_pkg and the assertion macro header.
`include "invalidation_history_ring_top_assert.svh"

module ihr_seq
    import ihr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cmd_t             in_cmd,
    input  logic [KEY_W-1:0] in_key,
    input  logic [GEN_W-1:0] in_since,
    output ring_req_t        ring_req,
    input  ring_rsp_t        ring_rsp,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [GEN_W-1:0]  since_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [GEN_W-1:0]  chk_gen_reg;
    logic [SPAN_W-1:0] left_reg;
    logic              flag_reg;

    logic              accept;
    logic [GEN_W-1:0]  gen_inc;
    logic              wrap;
    logic [GEN_W-1:0]  rec_gen;
    logic [SLOT_W-1:0] rec_slot;
    logic              rec_ok;
    logic [GEN_W-1:0]  dist_full;
    logic              q_same;
    logic              q_bad_range;
    logic [SPAN_W-1:0] q_span;
    logic [SPAN_W-1:0] back;
    logic [SPAN_W-1:0] start_sum;
    logic [SLOT_W-1:0] start_slot;
    logic              walk_hit;
    logic              walk_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Record path: advance the generation, restart at one on wrap.
    assign gen_inc  = gen_reg + 1'b1;
    assign wrap     = (gen_inc == '0);
    assign rec_gen  = wrap ? GEN_W'(1) : gen_inc;
    assign rec_slot = wrap ? '0 : next_slot(head_reg);
    assign rec_ok   = (in_key != '0);

    // Query range checks and the first slot of the walk.
    assign dist_full   = gen_reg - since_reg;
    assign q_same      = (gen_reg == since_reg);
    assign q_bad_range = (gen_reg < since_reg) || (dist_full > GEN_W'(HISTORY_DEPTH));
    assign q_span      = dist_full[SPAN_W-1:0];
    assign back        = q_span - 1'b1;
    assign start_sum   = {1'b0, head_reg} + DEPTH_SPAN - back;
    assign start_slot  = (start_sum >= DEPTH_SPAN) ? SLOT_W'(start_sum - DEPTH_SPAN)
                                                   : start_sum[SLOT_W-1:0];

    assign walk_hit  = (ring_rsp.stamp != chk_gen_reg) || (ring_rsp.key == key_reg);
    assign walk_last = (left_reg == SPAN_W'(1));

    always_comb begin
        ring_req          = '0;
        ring_req.wr_idx   = rec_slot;
        ring_req.wr_stamp = rec_gen;
        ring_req.wr_key   = in_key;
        ring_req.rd_idx   = rd_slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_cmd == CMD_RECORD && rec_ok) begin
                    ring_req.wr_en     = 1'b1;
                    ring_req.clear_all = wrap;
                end
            end
            ST_PREP: begin
                ring_req.rd_idx = start_slot;
                ring_req.rd_en  = (key_reg != '0) && !q_same && !q_bad_range;
            end
            ST_WALK: begin
                ring_req.rd_en = !walk_hit && !walk_last;
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gen_reg   <= '0;
            head_reg  <= LAST_SLOT;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg   <= in_key;
                        since_reg <= in_since;
                        if (in_cmd == CMD_RECORD) begin
                            flag_reg <= rec_ok;
                            if (rec_ok) begin
                                gen_reg  <= rec_gen;
                                head_reg <= rec_slot;
                            end
                            state_reg <= ST_HOLD;
                        end else begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    priority if (key_reg == '0) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_HOLD;
                    end else if (q_same) begin
                        flag_reg  <= 1'b0;
                        state_reg <= ST_HOLD;
                    end else if (q_bad_range) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_HOLD;
                    end else begin
                        rd_slot_reg <= next_slot(start_slot);
                        chk_gen_reg <= since_reg + 1'b1;
                        left_reg    <= q_span;
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    priority if (walk_hit) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_HOLD;
                    end else if (walk_last) begin
                        flag_reg  <= 1'b0;
                        state_reg <= ST_HOLD;
                    end else begin
                        rd_slot_reg <= next_slot(rd_slot_reg);
                        chk_gen_reg <= chk_gen_reg + 1'b1;
                        left_reg    <= left_reg - 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = (state_reg == ST_HOLD);
    assign res.flag  = flag_reg;
    assign res.gen   = gen_reg;

    `IHR_ASSERT_NOW(a_walk_span, aclk, aresetn, state_reg == ST_WALK,
        (left_reg != '0) && (left_reg <= DEPTH_SPAN), "walk count out of range")
    `IHR_ASSERT_NOW(a_walk_gen, aclk, aresetn, state_reg == ST_WALK,
        (gen_reg != '0) && (chk_gen_reg <= gen_reg) && (chk_gen_reg > since_reg),
        "walk generation outside the capture window")
    `IHR_ASSERT_NEXT(a_rec_adv, aclk, aresetn,
        accept && (in_cmd == CMD_RECORD) && (in_key != '0),
        (gen_reg != $past(gen_reg)) && (gen_reg != '0),
        "accepted record did not advance the generation")
    `IHR_ASSERT_NOW(a_write_only_idle, aclk, aresetn, ring_req.wr_en,
        accept && (state_reg == ST_IDLE), "ring write outside an accepted record")

endmodule

FILE: design/invalidation_history_ring_top.sv
// Top level of the invalidation history ring: stream ports, sequencer, ring storage
// and the result register. Depends on ihr_pkg, ihr_seq and ihr_ring.
//
//  Channel  | Direction | tdata (low bit up)                 | tuser
//  ---------+-----------+------------------------------------+---------------
//  s_       | request   | key[63:0], since_generation[63:0]  | command
//  m_       | result    | flag, current_generation[63:0]     | (none)
//
// Requests are taken one at a time. A record goes straight to the hold state; a query
// passes a prep state, then walks at most HISTORY_DEPTH ring slots through the single
// RAM read port. The input is ready again once the result has moved out of the hold
// state. Reset is synchronous and active low; the generation and all slot stamps read as
// zero right after it, with no clearing pass. A result waiting in the output register does
// not block the next request; a second finished result waits in the sequencer meanwhile.
module invalidation_history_ring_top
    import ihr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] key, [127:64] since_generation
    input  logic [0:0]   s_tuser,   // [0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // [0] flag, [64:1] current_generation, zero pad
);

    ring_req_t ring_req;
    ring_rsp_t ring_rsp;
    logic      res_valid;
    logic      res_ready;
    result_t   res;

    logic      m_valid_reg;
    result_t   m_res_reg;

    // The sequencer owns the generation counter and walks the ring slot by slot.
    ihr_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser[0])),
        .in_key    (s_tdata[KEY_W-1:0]),
        .in_since  (s_tdata[KEY_W+GEN_W-1:KEY_W]),
        .ring_req  (ring_req),
        .ring_rsp  (ring_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Stamps and keys live in one RAM; stamps of cleared slots read as zero.
    ihr_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ring_req),
        .rsp     (ring_rsp)
    );

    // Output register: loads when empty or when its current result is taken.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg.gen, m_res_reg.flag};

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the invalidation history ring top level.
// Depends on ihr_pkg and the invalidation_history_ring_top RTL; needs nothing else.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihr_pkg::*;

    localparam int RANDOM_OPS  = 950;
    localparam int QUIET_TAIL  = 100;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = HISTORY_DEPTH + 8;

    // One request on the input stream.
    typedef struct {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [GEN_W-1:0] since;
    } ring_op_t;

    // One result the block owes us.
    typedef struct {
        logic             flag;
        logic [GEN_W-1:0] gen;
    } answer_t;

    // A directed row; typed rows carry their expected result, the rest use the predictor.
    typedef struct {
        ring_op_t         op;
        bit               typed;
        logic             flag;
        logic [GEN_W-1:0] gen;
    } directed_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // [63:0] key, [127:64] since_generation
    logic [0:0]   s_tuser  = '0;   // [0] command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;         // [0] flag, [64:1] current_generation, zero pad

    // Shadow copy of the ring: generation counter, stamps and keys.
    logic [GEN_W-1:0] shadow_gen;
    logic [GEN_W-1:0] shadow_stamp [HISTORY_DEPTH];
    logic [KEY_W-1:0] shadow_key   [HISTORY_DEPTH];

    answer_t       queued_answers [$];
    directed_row_t directed_rows  [$];
    int unsigned   idle_pct    = 0;
    int unsigned   error_count = 0;
    int unsigned   idle_cycles = 0;

    invalidation_history_ring_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                   input logic [GEN_W-1:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%016h, want 0x%016h", $realtime, what, got, want);
    endtask

    function automatic int unsigned slot_for(input logic [GEN_W-1:0] g);
        return int'((g - 1) % HISTORY_DEPTH);
    endfunction

    // A record bumps the generation and stamps its slot; a zero key is refused.
    function automatic logic record_invalidation(input logic [KEY_W-1:0] key);
        int unsigned s;
        if (key == '0)
            return 1'b0;
        shadow_gen = shadow_gen + 1;
        if (shadow_gen == '0) begin
            foreach (shadow_stamp[i])
                shadow_stamp[i] = '0;
            shadow_gen = 1;
        end
        s = slot_for(shadow_gen);
        shadow_stamp[s] = shadow_gen;
        shadow_key[s]   = key;
        return 1'b1;
    endfunction

    // A query walks every generation after the capture, up to the current one.
    // Any gap in the history, or the key itself, means it may have been invalidated.
    function automatic logic may_be_invalidated(input logic [KEY_W-1:0] key,
                                                input logic [GEN_W-1:0] since);
        logic [GEN_W-1:0] g;
        logic [GEN_W-1:0] span;
        int unsigned      s;
        if (key == '0)
            return 1'b1;
        if (since == shadow_gen)
            return 1'b0;
        if (since > shadow_gen)
            return 1'b1;
        span = shadow_gen - since;
        if (span > HISTORY_DEPTH)
            return 1'b1;
        for (int k = 1; k <= int'(span); k++) begin
            g = since + k;
            s = slot_for(g);
            if (shadow_stamp[s] != g)
                return 1'b1;
            if (shadow_key[s] == key)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic answer_t apply_op(input ring_op_t op);
        answer_t ans;
        if (op.cmd == CMD_RECORD)
            ans.flag = record_invalidation(op.key);
        else
            ans.flag = may_be_invalidated(op.key, op.since);
        ans.gen = shadow_gen;
        return ans;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed traffic: captures close to the current generation and keys
    // taken from the ring, so that walks go deep; the rest is plain noise.
    function automatic ring_op_t make_random_op();
        ring_op_t    op;
        int unsigned pick;
        op.cmd   = ($urandom_range(0, 99) < 45) ? CMD_RECORD : CMD_QUERY;
        op.since = rand64();
        pick     = $urandom_range(0, 99);
        if (pick < 5)
            op.key = '0;
        else if (pick < 50)
            op.key = shadow_key[$urandom_range(0, HISTORY_DEPTH - 1)];
        else
            op.key = rand64();
        if (op.cmd == CMD_QUERY) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                op.since = shadow_gen - $urandom_range(0, HISTORY_DEPTH + 2);
            else if (pick < 70)
                op.since = shadow_gen;
            else if (pick < 80)
                op.since = shadow_gen + $urandom_range(1, 4);
            else if (pick < 85)
                op.since = '0;
        end
        return op;
    endfunction

    // Holds one request on the stream until it is taken, then files the expected result.
    task automatic send_op(input ring_op_t op, input bit typed, input logic t_flag,
                           input logic [GEN_W-1:0] t_gen);
        answer_t ans;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.since, op.key};
        s_tuser  <= op.cmd;
        do @(posedge aclk); while (!s_tready);
        ans = apply_op(op);
        if (typed) begin
            ans.flag = t_flag;
            ans.gen  = t_gen;
        end
        queued_answers.push_back(ans);
    endtask

    task automatic add_row(input cmd_t cmd, input logic [KEY_W-1:0] key,
                           input logic [GEN_W-1:0] since, input bit typed,
                           input logic flag, input logic [GEN_W-1:0] gen);
        directed_row_t row;
        row.op.cmd   = cmd;
        row.op.key   = key;
        row.op.since = since;
        row.typed    = typed;
        row.flag     = flag;
        row.gen      = gen;
        directed_rows.push_back(row);
    endtask

    // Directed table. Right after reset the generation is zero, so the first rows
    // can be read off directly: an invalid key always reports, a capture equal to
    // now reports nothing, a zero-key record is refused, and a capture ahead of
    // now reports. Fifteen more records then push the generation to 17, so a
    // capture of 0 is too old while a capture of 1 sits exactly at the ring depth.
    task automatic build_directed_table();
        add_row(CMD_QUERY,  '0,                    '0,   1'b1, 1'b1, 64'd0);
        add_row(CMD_QUERY,  64'd5,                 '0,   1'b1, 1'b0, 64'd0);
        add_row(CMD_RECORD, '0,                    '0,   1'b1, 1'b0, 64'd0);
        add_row(CMD_QUERY,  '1,                    '1,   1'b1, 1'b1, 64'd0);
        add_row(CMD_RECORD, '1,                    '0,   1'b1, 1'b1, 64'd1);
        add_row(CMD_RECORD, 64'd1,                 '1,   1'b1, 1'b1, 64'd2);
        add_row(CMD_QUERY,  64'd7,                 '0,   1'b0, 1'b0, '0);
        add_row(CMD_QUERY,  64'd1,                 '0,   1'b0, 1'b0, '0);
        add_row(CMD_QUERY,  '1,                    64'd1, 1'b0, 1'b0, '0);
        for (int i = 0; i < 15; i++)
            add_row(CMD_RECORD, 64'hA5A5_0000_0000_0000 | (64'(i + 1) << (4 * i)),
                    rand64(), 1'b0, 1'b0, '0);
        add_row(CMD_QUERY,  64'd7,                 '0,   1'b1, 1'b1, 64'd17);
        add_row(CMD_QUERY,  64'd3,                 64'd1, 1'b0, 1'b0, '0);
    endtask

    // Request side: reset, directed table, random phases with varying idle rates,
    // then a quiet tail, a drain and the verdict.
    initial begin
        shadow_gen = '0;
        foreach (shadow_stamp[i]) begin
            shadow_stamp[i] = '0;
            shadow_key[i]   = '0;
        end
        build_directed_table();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        idle_pct = 20;
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].typed,
                    directed_rows[i].flag, directed_rows[i].gen);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n >= RANDOM_OPS - QUIET_TAIL)
                idle_pct = 0;
            else
                case ((n / 120) % 5)
                    0: idle_pct = 10;
                    1: idle_pct = 0;
                    2: idle_pct = 40;
                    3: idle_pct = 25;
                    default: idle_pct = 5;
                endcase
            send_op(make_random_op(), 1'b0, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // The watchdog catches a result that never shows up.
        while (queued_answers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("invalidation_history_ring_top regression: pass");
        else
            $display("invalidation_history_ring_top regression: fail");
        $finish;
    end

    // Result side backpressure: random stall bursts while idle_pct is nonzero.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker and watchdog. Values are read at the edge before any
    // nonblocking update of that edge lands, so they are the ones the handshake saw.
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready) begin
                if (queued_answers.size() == 0) begin
                    report_mismatch("unexpected result", GEN_W'(m_tdata), '0);
                end else begin
                    want = queued_answers.pop_front();
                    if (m_tdata[0] !== want.flag)
                        report_mismatch("flag", GEN_W'(m_tdata[0]), GEN_W'(want.flag));
                    if (m_tdata[64:1] !== want.gen)
                        report_mismatch("current_generation", m_tdata[64:1], want.gen);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] watchdog: no request or result moved for %0d cycles",
                         $realtime, IDLE_LIMIT);
                $display("invalidation_history_ring_top regression: fail");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
+incdir+design
design/ihr_pkg.sv
design/ihr_ram.sv
design/ihr_ring.sv
design/ihr_seq.sv
design/invalidation_history_ring_top.sv
tb/sv/tb.sv
